@@ hw/rtl/ths_pkg.sv @@
// Shared types, codes and helpers for the traceroute hop sequencer.
package ths_pkg;

    localparam int unsigned TTL_W   = 8;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned OP_W    = 3;
    localparam int unsigned ACT_W   = 3;
    localparam int unsigned HOP_W   = TTL_W + 1;

    localparam logic [TTL_W-1:0]  START_TTL_RST   = 8'd1;
    localparam logic [TTL_W-1:0]  MAX_TTL_RST     = 8'd30;
    localparam logic [CNT_W-1:0]  PROBES_RST      = 8'd3;
    localparam logic [CNT_W-1:0]  MAX_SILENT_RST  = 8'd3;
    localparam logic [ADDR_W-1:0] TARGET_RST      = '0;

    typedef enum logic [IDX_W-1:0] {
        CFG_START_TTL      = 3'd0,
        CFG_MAX_TTL        = 3'd1,
        CFG_PROBES_PER_HOP = 3'd2,
        CFG_MAX_SILENT     = 3'd3,
        CFG_TARGET_ADDR    = 3'd4
    } cfg_idx_t;

    typedef enum logic [OP_W-1:0] {
        OP_START     = 3'd0,
        OP_REPLY     = 3'd1,
        OP_TIMEOUT   = 3'd2,
        OP_TERMINATE = 3'd3,
        OP_ERROR     = 3'd4
    } op_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE       = 3'd0,
        ACT_SEND       = 3'd1,
        ACT_TARGET     = 3'd2,
        ACT_MAX_TTL    = 3'd3,
        ACT_SILENT     = 3'd4,
        ACT_ERROR      = 3'd5
    } act_t;

    typedef struct packed {
        logic [TTL_W-1:0]  start_ttl;
        logic [TTL_W-1:0]  max_ttl;
        logic [CNT_W-1:0]  probes_per_hop;
        logic [CNT_W-1:0]  max_silent_hops;
        logic [ADDR_W-1:0] target_address;
    } cfg_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [TTL_W-1:0] probe_ttl;
        logic [CNT_W-1:0] probe_count;
    } res_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
    endfunction

    function automatic logic [CNT_W-1:0] at_least_one(input logic [CNT_W-1:0] v);
        at_least_one = (v == '0) ? {{(CNT_W-1){1'b0}}, 1'b1} : v;
    endfunction

endpackage

@@ hw/rtl/traceroute_hop_sequencer_top.sv @@
// Top level of the traceroute hop sequencer: input register, core, result register.
//
//  channel | direction | handshake             | word
//  in      | to block  | in_valid / in_stall   | operation, reply_source
//  out     | from block| out_valid / out_stall | action, probe_ttl, probe_count
//  cfg     | to block  | cfg_write             | cfg_index, cfg_data
//
// One word per cycle unless out_stall holds; path: input register, result register.
// The state counters update in the cycle the word moves from input to result register.
// out_stall holds both registers; in_stall rises only while both are full and held.
// Reset clears all counters and leaves the block idle with default configuration.
module traceroute_hop_sequencer_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [ths_pkg::IDX_W-1:0]   cfg_index,
    input  logic [ths_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [ths_pkg::OP_W-1:0]    operation,
    input  logic [ths_pkg::ADDR_W-1:0]  reply_source,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ths_pkg::ACT_W-1:0]   action,
    output logic [ths_pkg::TTL_W-1:0]   probe_ttl,
    output logic [ths_pkg::CNT_W-1:0]   probe_count
);
    import ths_pkg::*;

    cfg_t              cfg;
    res_t              res;
    logic              s1_valid_reg;
    logic [OP_W-1:0]   s1_op_reg;
    logic [ADDR_W-1:0] s1_src_reg;
    logic              out_valid_reg;
    res_t              out_res_reg;
    logic              adv;
    logic              fire;
    logic              s1_load;

    assign adv      = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && adv;
    assign in_stall = s1_valid_reg && !adv;
    assign s1_load  = in_valid && !in_stall;

    ths_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ths_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .fire  (fire),
        .op    (s1_op_reg),
        .src   (s1_src_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
        end
    end

    // Payload registers: load on move, hold otherwise
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_op_reg  <= operation;
            s1_src_reg <= reply_source;
        end
        if (fire)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign action      = out_res_reg.action;
    assign probe_ttl   = out_res_reg.probe_ttl;
    assign probe_count = out_res_reg.probe_count;

endmodule

@@ hw/rtl/ths_cfg.sv @@
// Configuration register file for the traceroute hop sequencer.
module ths_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [ths_pkg::IDX_W-1:0]  cfg_index,
    input  logic [ths_pkg::CFG_W-1:0]  cfg_data,
    output ths_pkg::cfg_t              cfg
);
    import ths_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_START_TTL:      cfg_next.start_ttl       = cfg_data[TTL_W-1:0];
                CFG_MAX_TTL:        cfg_next.max_ttl         = cfg_data[TTL_W-1:0];
                CFG_PROBES_PER_HOP: cfg_next.probes_per_hop  = cfg_data[CNT_W-1:0];
                CFG_MAX_SILENT:     cfg_next.max_silent_hops = cfg_data[CNT_W-1:0];
                CFG_TARGET_ADDR:    cfg_next.target_address  = cfg_data[ADDR_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_ttl       <= START_TTL_RST;
            cfg_reg.max_ttl         <= MAX_TTL_RST;
            cfg_reg.probes_per_hop  <= PROBES_RST;
            cfg_reg.max_silent_hops <= MAX_SILENT_RST;
            cfg_reg.target_address  <= TARGET_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/ths_core.sv @@
// Hop sequencing state and the per-event decision logic.
module ths_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ths_pkg::cfg_t               cfg,
    input  logic                        fire,
    input  logic [ths_pkg::OP_W-1:0]    op,
    input  logic [ths_pkg::ADDR_W-1:0]  src,
    output ths_pkg::res_t               res
);
    import ths_pkg::*;

    logic [HOP_W-1:0] hop_ttl_reg, hop_ttl_next;
    logic [CNT_W-1:0] replies_reg, replies_next;
    logic [CNT_W-1:0] silent_probes_reg, silent_probes_next;
    logic [CNT_W-1:0] silent_hops_reg, silent_hops_next;
    logic             target_seen_reg, target_seen_next;
    logic             running_reg, running_next;

    logic [CNT_W-1:0] probes;
    logic [CNT_W-1:0] max_silent;
    logic [CNT_W-1:0] sp_upd;
    logic [CNT_W-1:0] sh_upd;
    logic [CNT_W-1:0] sh_hop;
    logic [CNT_W-1:0] rih_upd;
    logic             ts_upd;
    logic             hop_over;

    assign probes     = at_least_one(cfg.probes_per_hop);
    assign max_silent = at_least_one(cfg.max_silent_hops);
    assign hop_over   = hop_ttl_reg > {1'b0, cfg.max_ttl};
    assign rih_upd    = sat_inc(replies_reg);
    assign sh_hop     = sat_inc(sh_upd);

    // Counter updates common to reply and timeout
    always_comb
    begin
        if (op_t'(op) == OP_REPLY)
        begin
            sp_upd = '0;
            sh_upd = '0;
            ts_upd = target_seen_reg | (src == cfg.target_address);
        end
        else
        begin
            sp_upd = sat_inc(silent_probes_reg);
            sh_upd = silent_hops_reg;
            ts_upd = target_seen_reg;
        end
    end

    always_comb
    begin
        hop_ttl_next       = hop_ttl_reg;
        replies_next       = replies_reg;
        silent_probes_next = silent_probes_reg;
        silent_hops_next   = silent_hops_reg;
        target_seen_next   = target_seen_reg;
        running_next       = running_reg;
        res.action         = ACT_NONE;
        res.probe_ttl      = '0;
        res.probe_count    = '0;

        if (op_t'(op) == OP_START)
        begin
            if (cfg.start_ttl > cfg.max_ttl)
            begin
                running_next = 1'b0;
                res.action   = ACT_ERROR;
            end
            else
            begin
                hop_ttl_next       = {1'b0, cfg.start_ttl} + {{(HOP_W-1){1'b0}}, 1'b1};
                replies_next       = '0;
                silent_probes_next = '0;
                silent_hops_next   = '0;
                target_seen_next   = 1'b0;
                running_next       = 1'b1;
                res.action         = ACT_SEND;
                res.probe_ttl      = cfg.start_ttl;
                res.probe_count    = probes;
            end
        end
        else if (running_reg)
        begin
            case (op_t'(op))
                OP_TERMINATE:
                begin
                    running_next = 1'b0;
                end
                OP_ERROR:
                begin
                    running_next = 1'b0;
                    res.action   = ACT_ERROR;
                end
                OP_REPLY, OP_TIMEOUT:
                begin
                    silent_probes_next = sp_upd;
                    silent_hops_next   = sh_upd;
                    target_seen_next   = ts_upd;
                    replies_next       = rih_upd;
                    if (rih_upd >= probes)
                    begin
                        // Hop complete: decide stop or next batch
                        replies_next = '0;
                        if (ts_upd)
                        begin
                            running_next = 1'b0;
                            res.action   = ACT_TARGET;
                        end
                        else if (hop_over)
                        begin
                            running_next = 1'b0;
                            res.action   = ACT_MAX_TTL;
                        end
                        else
                        begin
                            if (sp_upd >= probes)
                            begin
                                silent_hops_next = sh_hop;
                            end
                            if ((sp_upd >= probes) && (sh_hop >= max_silent))
                            begin
                                running_next = 1'b0;
                                res.action   = ACT_SILENT;
                            end
                            else
                            begin
                                silent_probes_next = '0;
                                hop_ttl_next       = hop_ttl_reg + {{(HOP_W-1){1'b0}}, 1'b1};
                                res.action         = ACT_SEND;
                                res.probe_ttl      = hop_ttl_reg[TTL_W-1:0];
                                res.probe_count    = probes;
                            end
                        end
                    end
                end
                default:
                begin
                    running_next = running_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hop_ttl_reg       <= '0;
            replies_reg       <= '0;
            silent_probes_reg <= '0;
            silent_hops_reg   <= '0;
            target_seen_reg   <= 1'b0;
            running_reg       <= 1'b0;
        end
        else if (fire)
        begin
            hop_ttl_reg       <= hop_ttl_next;
            replies_reg       <= replies_next;
            silent_probes_reg <= silent_probes_next;
            silent_hops_reg   <= silent_hops_next;
            target_seen_reg   <= target_seen_next;
            running_reg       <= running_next;
        end
    end

endmodule

@@ hw/rtl/ths_checker.sv @@
// Port-level checks for the traceroute hop sequencer, bound to the top level.
module ths_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_stall,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [ths_pkg::ACT_W-1:0]   action,
    input  logic [ths_pkg::TTL_W-1:0]   probe_ttl,
    input  logic [ths_pkg::CNT_W-1:0]   probe_count
);
    import ths_pkg::*;

    // A held result word keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(action)
            && $stable(probe_ttl) && $stable(probe_count))
        else $error("result word changed while stalled");

    // Input back-pressure only when the result side is full and held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // A batch order always carries at least one probe
    a_send_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action == ACT_SEND) |-> probe_count != '0)
        else $error("batch ordered with zero probes");

    // Any other action carries no TTL or count
    a_other_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action != ACT_SEND) |-> (probe_ttl == '0) && (probe_count == '0))
        else $error("non-batch action with TTL or count set");

endmodule

bind traceroute_hop_sequencer_top ths_checker u_ths_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .action      (action),
    .probe_ttl   (probe_ttl),
    .probe_count (probe_count)
);
